[hdl/vrx_pkg.sv]
package vrx_pkg;

  // fixed-point and field widths
  localparam int unsigned FracBits  = 16;
  localparam int unsigned TimeInW   = 62;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned CountW    = 32;
  localparam int unsigned FrameW    = 48;
  localparam int unsigned DrainW    = 40;
  localparam int unsigned OffW      = 30;
  localparam int unsigned DeltaW    = TimeW - FracBits;
  localparam int unsigned DvdW      = TimeInW + FracBits;
  localparam int unsigned CntW      = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 80;

  // reset values of the registers
  localparam logic [FrameW-1:0] FramePeriodRst = 48'd1093358933312;
  localparam logic [DrainW-1:0] DrainPeriodRst = 40'd486539264;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFramePeriod = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDrainPeriod = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIdealOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartMode   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOvrEnable   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOvrOffset   = 3'd5;

  // step counts of the shared shift-subtract unit and the multiplier
  localparam logic [CntW-1:0] ModSteps = CntW'(DvdW - 1);
  localparam logic [CntW-1:0] DivSteps = CntW'(TimeW - 1);
  localparam logic [CntW-1:0] MulSteps = CntW'(CountW - 1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMod   = 7'b0000010,
    StMul   = 7'b0000100,
    StSet   = 7'b0001000,
    StDInit = 7'b0010000,
    StDiv   = 7'b0100000,
    StFin   = 7'b1000000
  } vrx_state_e;

  typedef struct packed {
    logic load;
    logic mod_init;
    logic mul_init;
    logic step;
    logic mul_step;
    logic set_start;
    logic div_init;
    logic out_load;
  } vrx_cmd_t;

  typedef struct packed {
    logic mode;
    logic cnt_last;
  } vrx_stat_t;

endpackage

[hdl/vrx_ctrl.sv]
module vrx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_fs_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  vrx_pkg::vrx_stat_t  stat_i,
  output vrx_pkg::vrx_cmd_t   cmd_o
);

  vrx_pkg::vrx_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      vrx_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_fs_i && stat_i.mode) begin
            cmd_o.mul_init = 1'b1;
            state_d        = vrx_pkg::StMul;
          end else if (in_fs_i) begin
            cmd_o.mod_init = 1'b1;
            state_d        = vrx_pkg::StMod;
          end else begin
            state_d = vrx_pkg::StDInit;
          end
        end
      end
      vrx_pkg::StMod: begin
        cmd_o.step = 1'b1;
        if (stat_i.cnt_last) state_d = vrx_pkg::StSet;
      end
      vrx_pkg::StMul: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.cnt_last) state_d = vrx_pkg::StSet;
      end
      vrx_pkg::StSet: begin
        cmd_o.set_start = 1'b1;
        state_d         = vrx_pkg::StDInit;
      end
      vrx_pkg::StDInit: begin
        cmd_o.div_init = 1'b1;
        state_d        = vrx_pkg::StDiv;
      end
      vrx_pkg::StDiv: begin
        cmd_o.step = 1'b1;
        if (stat_i.cnt_last) state_d = vrx_pkg::StFin;
      end
      vrx_pkg::StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = vrx_pkg::StIdle;
        end
      end
      default: state_d = vrx_pkg::StIdle;
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrx_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == vrx_pkg::StIdle);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/vrx_dp.sv]
module vrx_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vrx_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [vrx_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic [vrx_pkg::TimeInW-1:0]          in_time_i,
  input  logic                                 in_fs_i,
  input  vrx_pkg::vrx_cmd_t                    cmd_i,
  output vrx_pkg::vrx_stat_t                   stat_o,
  output logic signed [vrx_pkg::CountW-1:0]    level_o,
  output logic signed [vrx_pkg::DeltaW-1:0]    delta_o,
  output logic                                 delta_valid_o
);

  localparam int unsigned TW = vrx_pkg::TimeW;
  localparam int unsigned CW = vrx_pkg::CountW;
  localparam int unsigned FW = vrx_pkg::FrameW;

  // saturation bounds of the level sum
  localparam logic signed [CW+2:0] SumMax = $signed({3'b000, 1'b0, {(CW-1){1'b1}}});
  localparam logic signed [CW+2:0] SumMin = $signed({3'b111, 1'b1, {(CW-1){1'b0}}});

  // configuration registers
  logic [FW-1:0]                  frame_q;
  logic [vrx_pkg::DrainW-1:0]     drain_q;
  logic [vrx_pkg::OffW-1:0]       ideal_q, ovr_q;
  logic                           mode_q, ovr_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= vrx_pkg::FramePeriodRst;
      drain_q  <= vrx_pkg::DrainPeriodRst;
      ideal_q  <= '0;
      ovr_q    <= '0;
      mode_q   <= 1'b0;
      ovr_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vrx_pkg::RegFramePeriod: frame_q  <= cfg_data_i[FW-1:0];
        vrx_pkg::RegDrainPeriod: drain_q  <= cfg_data_i[vrx_pkg::DrainW-1:0];
        vrx_pkg::RegIdealOffset: ideal_q  <= cfg_data_i[vrx_pkg::OffW-1:0];
        vrx_pkg::RegStartMode:   mode_q   <= cfg_data_i[0];
        vrx_pkg::RegOvrEnable:   ovr_en_q <= cfg_data_i[0];
        vrx_pkg::RegOvrOffset:   ovr_q    <= cfg_data_i[vrx_pkg::OffW-1:0];
        default: ;
      endcase
    end
  end

  // zero periods count as one
  logic [FW-1:0]              p_eff;
  logic [vrx_pkg::DrainW-1:0] d_eff;
  assign p_eff = (frame_q == '0) ? FW'(1) : frame_q;
  assign d_eff = (drain_q == '0) ? vrx_pkg::DrainW'(1) : drain_q;

  // item and stream state
  logic [TW-1:0]      tq_q, start_q, first_q;
  logic               fs_q, first_seen_q, neg_q, div_sel_q;
  logic [CW-1:0]      frames_q;
  logic signed [CW-1:0] level_prev_q, drained_prev_q;

  // shared shift-subtract unit: remainder of t*2^16 by the frame period,
  // then the drain count quotient
  logic [vrx_pkg::DvdW-1:0] dvd_q;
  logic [FW-1:0]            rem_q;
  logic [FW:0]              rem2, divisor;
  logic                     ge;
  logic [vrx_pkg::CntW-1:0] cnt_q;

  assign divisor = div_sel_q ? (FW+1)'(d_eff) : {1'b0, p_eff};
  assign rem2    = {rem_q, dvd_q[vrx_pkg::DvdW-1]};
  assign ge      = (rem2 >= divisor);

  // serial multiplier for first-packet anchored start
  logic [TW-1:0] acc_q, mcand_q;
  logic [CW-1:0] mplier_q;

  // division operand setup
  logic [TW-1:0]   x;
  logic [TW:0]     s, s_neg;
  logic [TW-1:0]   n;
  assign x     = tq_q - start_q;
  assign s     = {x[TW-1], x} + (TW+1)'(d_eff);
  assign s_neg = -s;
  assign n     = s[TW] ? s_neg[TW-1:0] : s[TW-1:0];

  // drain start for a frame start packet
  logic [TW-1:0] start_new;
  logic [vrx_pkg::OffW-1:0] off;
  assign off = ovr_en_q ? ovr_q : ideal_q;
  always_comb begin
    if (mode_q) start_new = first_q + acc_q;
    else start_new = tq_q - TW'(rem_q) + (TW'(off) << vrx_pkg::FracBits);
  end

  // saturated drain count and level
  logic [TW-1:0]          q;
  logic signed [CW-1:0]   drained, lp, dp;
  logic signed [CW+2:0]   lsum;
  logic signed [CW-1:0]   level;
  logic [TW-1:0]          u;
  assign q = dvd_q[TW-1:0];
  always_comb begin
    if (!neg_q) begin
      drained = (q[TW-1:CW-1] != '0) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    end else begin
      drained = (q > (TW'(1) << (CW-1))) ? {1'b1, {(CW-1){1'b0}}} : -q[CW-1:0];
    end
    lp   = fs_q ? '0 : level_prev_q;
    dp   = fs_q ? '0 : drained_prev_q;
    lsum = (CW+3)'(lp) + (CW+3)'(1) - (CW+3)'(drained) + (CW+3)'(dp);
    if (lsum > SumMax) level = {1'b0, {(CW-1){1'b1}}};
    else if (lsum < SumMin) level = {1'b1, {(CW-1){1'b0}}};
    else level = lsum[CW-1:0];
  end
  assign u = start_q - tq_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q        <= '0;
      first_q        <= '0;
      first_seen_q   <= 1'b0;
      frames_q       <= '0;
      level_prev_q   <= '0;
      drained_prev_q <= '0;
      cnt_q          <= '0;
    end else begin
      if (cmd_i.load && in_fs_i) frames_q <= frames_q + CW'(1);
      if (cmd_i.mul_init && !first_seen_q) begin
        first_q      <= {in_time_i[TW-vrx_pkg::FracBits-1:0], {vrx_pkg::FracBits{1'b0}}};
        first_seen_q <= 1'b1;
      end
      if (cmd_i.set_start) start_q <= start_new;
      if (cmd_i.mod_init) cnt_q <= vrx_pkg::ModSteps;
      else if (cmd_i.mul_init) cnt_q <= vrx_pkg::MulSteps;
      else if (cmd_i.div_init) cnt_q <= vrx_pkg::DivSteps;
      else if (cmd_i.step || cmd_i.mul_step) cnt_q <= cnt_q - vrx_pkg::CntW'(1);
      if (cmd_i.out_load) begin
        level_prev_q   <= level;
        drained_prev_q <= drained;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tq_q <= {in_time_i[TW-vrx_pkg::FracBits-1:0], {vrx_pkg::FracBits{1'b0}}};
      fs_q <= in_fs_i;
    end
    if (cmd_i.mod_init) begin
      dvd_q     <= {in_time_i, {vrx_pkg::FracBits{1'b0}}};
      rem_q     <= '0;
      div_sel_q <= 1'b0;
    end else if (cmd_i.div_init) begin
      dvd_q     <= {n, {(vrx_pkg::DvdW-TW){1'b0}}};
      rem_q     <= '0;
      div_sel_q <= 1'b1;
      neg_q     <= s[TW];
    end else if (cmd_i.step) begin
      dvd_q <= {dvd_q[vrx_pkg::DvdW-2:0], ge};
      rem_q <= ge ? FW'(rem2 - divisor) : rem2[FW-1:0];
    end
    if (cmd_i.mul_init) begin
      acc_q    <= '0;
      mcand_q  <= TW'(p_eff);
      mplier_q <= frames_q;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    if (cmd_i.out_load) begin
      level_o       <= level;
      delta_o       <= fs_q ? u[TW-1:vrx_pkg::FracBits] : '0;
      delta_valid_o <= fs_q;
    end
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.cnt_last = (cnt_q == '0);

endmodule

[hdl/st2110_vrx_buffer_model.sv]
// sequence: a packet opening no frame runs the quotient steps only; a frame opener
//   first runs the multiplier in first-packet mode or the remainder steps in aligned mode
// flow: one packet at a time; the next is taken only once the result is loaded, which
//   waits while the output is stalled; set by the one-bit-per-cycle shift-subtract unit
//   (78 remainder steps, 64 quotient steps) and the 32-step multiplier
// reset: asynchronous active low, registers to defaults, stream state cleared
module st2110_vrx_buffer_model (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vrx_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vrx_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // arrival time in ns [61:0], zero fill
  input  logic [vrx_pkg::InDataW-1:0]     s_axis_tdata_i,
  // frame opener flag
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // vrx_level [31:0], start_delta_ns [79:32]
  output logic [vrx_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // delta_valid
  output logic                            m_axis_tuser_o
);

  vrx_pkg::vrx_cmd_t                     cmd;
  vrx_pkg::vrx_stat_t                    stat;
  logic signed [vrx_pkg::CountW-1:0]     level;
  logic signed [vrx_pkg::DeltaW-1:0]     delta;

  assign cfg_ready_o = 1'b1;

  vrx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_fs_i     (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  vrx_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_idx_i     (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_time_i     (s_axis_tdata_i[vrx_pkg::TimeInW-1:0]),
    .in_fs_i       (s_axis_tuser_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .level_o       (level),
    .delta_o       (delta),
    .delta_valid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {delta, level};

  // one packet in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a packet is in flight");

  // offset only reported on a frame start
  a_delta_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[79:32] == '0)
    else $error("start offset set on a packet that opens no frame");

  // a new result only appears after a packet was in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result without a packet in flight");

endmodule
